FILE: hdl/ftn_pkg.sv
// Constants, types and the log2 table generator for the note finder.
// Used by frequency_to_note_and_cents_unit.
`timescale 1ns / 1ps
`default_nettype none

package ftn_pkg;

  localparam int SEMIS       = 12;
  localparam int A_OFFSET    = 9;     // A sits nine semitones above C
  localparam int BASE_OCTAVE = 4;
  localparam int CENTS_SCALE = 10000; // hundredths of a cent per semitone
  localparam int LOG_Q       = 24;
  localparam int MANT_BITS   = 23;

  // floor(u / 12) as (u * 2731) >> 15, exact for u below 600
  localparam int RECIP12     = 2731;
  localparam int RECIP12_SH  = 15;

  localparam logic signed [4:0] OCT_MIN = -5'sd16;
  localparam logic signed [4:0] OCT_MAX = 5'sd15;

  // 2^(r/12) in Q1.16, rounded to nearest
  localparam logic [16:0] RATIO_Q16 [SEMIS] = '{
    17'd65536,  17'd69433,  17'd73562,  17'd77936,
    17'd82570,  17'd87480,  17'd92682,  17'd98193,
    17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  typedef struct packed {
    logic [4:0]  p;   // leading-one position
    logic [22:0] fr;  // bits below the leading one
  } norm_t;

  // log2(1 + idx/2^tbits) in Q1.24 by repeated squaring in Q1.30
  function automatic logic [24:0] log_rom_entry(input int idx, input int tbits);
    longint unsigned y;
    logic [24:0]     acc;
    logic [25:0]     rnd;
    if (idx >= (1 << tbits)) begin
      return 25'(1) << LOG_Q;
    end
    y   = (64'd1 << 30) + (64'(idx) << (30 - tbits));
    acc = '0;
    for (int k = 0; k < LOG_Q + 1; k++) begin
      y   = (y * y) >> 30;
      acc = acc << 1;
      if (y >= (64'd1 << 31)) begin
        y      = y >> 1;
        acc[0] = 1'b1;
      end
    end
    rnd = (26'(acc) + 26'd1) >> 1;
    return rnd[24:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/frequency_to_note_and_cents_unit.sv
// Frequency to nearest equal-tempered note, octave, note frequency and cents.
// Nine-stage pipeline; depends on ftn_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One frequency item in, one result item out on res_valid. A new item is taken
// every cycle while freq_stall is low; each stage holds while the one
// after it is full and stalled, so bubbles are squeezed out before freq_stall
// rises. freq_in and the A4 reference share a format (unsigned, same
// fraction bits). log2 of each comes from leading-one normalisation plus a
// 2^LOG_TABLE_BITS + 1 entry table with linear interpolation; the semitone
// offset is rounded half away from zero. A zero frequency or a zero reference
// gives valid_res low and all other fields zero. octave_number saturates to
// -16..15, target_freq at its field maximum. Write reference_a4 via
// cfg_write/cfg_data only while no item is in flight.
module frequency_to_note_and_cents_unit #(
  parameter int LOG_TABLE_BITS = 6
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_write,
  input  wire  [20:0]        cfg_data,
  input  wire                freq_valid,
  output logic               freq_stall,
  input  wire  [23:0]        freq_in,
  output logic               res_valid,
  input  wire                res_stall,
  output logic               valid_res,
  output logic [3:0]         pitch_class,
  output logic signed [4:0]  octave_number,
  output logic [23:0]        target_freq,
  output logic signed [13:0] cent_dev
);

  localparam int NSTG   = 9;
  localparam int RBITS  = ftn_pkg::MANT_BITS - LOG_TABLE_BITS;
  localparam int TAB    = (1 << LOG_TABLE_BITS) + 1;
  localparam int PW     = 25 + RBITS;
  localparam int LOG_W  = 30;
  localparam int OFS_OCT = 25;  // keeps n + 9 positive before the divide by 12

  // log2 table (constant logic)
  logic [24:0] log_rom [TAB];
  for (genvar g = 0; g < TAB; g++) begin : g_rom
    assign log_rom[g] = ftn_pkg::log_rom_entry(g, LOG_TABLE_BITS);
  end

  function automatic ftn_pkg::norm_t normalise(input logic [23:0] x);
    ftn_pkg::norm_t r;
    logic [23:0]    sh;
    r.p = '0;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) r.p = 5'(i);
    end
    sh   = x << (5'd23 - r.p);
    r.fr = sh[22:0];
    return r;
  endfunction

  // reference register
  logic [20:0] reference_a4;
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_a4 <= 21'd1802240;
    end else if (cfg_write) begin
      reference_a4 <= cfg_data;
    end
  end

  // per-stage valid and ready
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || !res_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld & ~rdy) | ({vld[NSTG-2:0], freq_valid} & rdy);
    end
  end

  assign freq_stall = !rdy[0];
  assign res_valid  = vld[NSTG-1];

  // stage 1: capture
  logic [23:0] s1_f;
  always_ff @(posedge clk) begin
    if (rdy[0]) s1_f <= freq_in;
  end

  // stage 2: normalise both
  ftn_pkg::norm_t s2_nf, s2_nr;
  logic           s2_ok;
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_nf <= normalise(s1_f);
      s2_nr <= normalise({3'b0, reference_a4});
      s2_ok <= (s1_f != '0) && (reference_a4 != '0);
    end
  end

  // stage 3: table lookup
  logic [LOG_TABLE_BITS:0] idx_f, idx_r;
  logic [24:0]             lo_f, hi_f, lo_r, hi_r;
  always_comb begin
    idx_f = {1'b0, s2_nf.fr[22:RBITS]};
    idx_r = {1'b0, s2_nr.fr[22:RBITS]};
    lo_f  = log_rom[idx_f];
    hi_f  = log_rom[idx_f + 1'b1];
    lo_r  = log_rom[idx_r];
    hi_r  = log_rom[idx_r + 1'b1];
  end

  logic [4:0]       s3_pf, s3_pr;
  logic [24:0]      s3_lof, s3_lor, s3_dff, s3_dfr;
  logic [RBITS-1:0] s3_remf, s3_remr;
  logic             s3_ok;
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_pf   <= s2_nf.p;
      s3_pr   <= s2_nr.p;
      s3_lof  <= lo_f;
      s3_lor  <= lo_r;
      s3_dff  <= hi_f - lo_f;
      s3_dfr  <= hi_r - lo_r;
      s3_remf <= s2_nf.fr[RBITS-1:0];
      s3_remr <= s2_nr.fr[RBITS-1:0];
      s3_ok   <= s2_ok;
    end
  end

  // stage 4: interpolation products
  logic [4:0]    s4_pf, s4_pr;
  logic [24:0]   s4_lof, s4_lor;
  logic [PW-1:0] s4_prf, s4_prr;
  logic          s4_ok;
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_pf  <= s3_pf;
      s4_pr  <= s3_pr;
      s4_lof <= s3_lof;
      s4_lor <= s3_lor;
      s4_prf <= PW'(s3_dff) * PW'(s3_remf);
      s4_prr <= PW'(s3_dfr) * PW'(s3_remr);
      s4_ok  <= s3_ok;
    end
  end

  // stage 5: log values and their difference
  logic [PW:0]      isum_f, isum_r;
  logic [LOG_W-1:0] log_f, log_r;
  always_comb begin
    isum_f = (PW+1)'(s4_prf) + ((PW+1)'(1) << (RBITS - 1));
    isum_r = (PW+1)'(s4_prr) + ((PW+1)'(1) << (RBITS - 1));
    log_f  = (LOG_W'(s4_pf) << ftn_pkg::LOG_Q) + LOG_W'(s4_lof) + LOG_W'(isum_f >> RBITS);
    log_r  = (LOG_W'(s4_pr) << ftn_pkg::LOG_Q) + LOG_W'(s4_lor) + LOG_W'(isum_r >> RBITS);
  end

  logic signed [LOG_W:0] s5_d;
  logic                  s5_ok;
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_d  <= $signed({1'b0, log_f}) - $signed({1'b0, log_r});
      s5_ok <= s4_ok;
    end
  end

  // stage 6: semitones, rounded half away from zero
  logic signed [34:0] dx, semi;
  logic [34:0]        smag, nsum;
  logic [10:0]        nmag;
  always_comb begin
    dx   = 35'(s5_d);
    semi = (dx <<< 3) + (dx <<< 2);
    smag = semi[34] ? 35'(-semi) : 35'(semi);
    nsum = (smag + (35'd1 << (ftn_pkg::LOG_Q - 1))) >> ftn_pkg::LOG_Q;
    nmag = nsum[10:0];
  end

  logic signed [34:0] s6_s;
  logic signed [11:0] s6_n;
  logic               s6_ok;
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_s  <= semi;
      s6_n  <= semi[34] ? -$signed({1'b0, nmag}) : $signed({1'b0, nmag});
      s6_ok <= s5_ok;
    end
  end

  // stage 7: note, octave, residual
  logic [9:0]         u;
  logic [20:0]        qprod;
  logic [5:0]         q;
  logic [3:0]         note;
  logic signed [6:0]  q1, oct7;
  logic signed [4:0]  oct;
  logic signed [34:0] e;
  always_comb begin
    u     = 10'(s6_n + 12'(ftn_pkg::A_OFFSET + ftn_pkg::SEMIS * OFS_OCT));
    qprod = 21'(u) * 21'(ftn_pkg::RECIP12);
    q     = qprod[ftn_pkg::RECIP12_SH +: 6];
    note  = 4'(u - 10'(q) * 10'(ftn_pkg::SEMIS));
    q1    = $signed({1'b0, q}) - 7'(OFS_OCT);
    oct7  = q1 + 7'(ftn_pkg::BASE_OCTAVE);
    if (oct7 < 7'(ftn_pkg::OCT_MIN)) begin
      oct = ftn_pkg::OCT_MIN;
    end else if (oct7 > 7'(ftn_pkg::OCT_MAX)) begin
      oct = ftn_pkg::OCT_MAX;
    end else begin
      oct = oct7[4:0];
    end
    e = s6_s - (35'(s6_n) <<< ftn_pkg::LOG_Q);
  end

  logic [3:0]        s7_note, s7_r;
  logic signed [6:0] s7_qt;
  logic signed [4:0] s7_oct;
  logic [23:0]       s7_emag;
  logic              s7_eneg, s7_ok;
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s7_note <= note;
      // semitone within the octave counted from A, and that octave's shift
      if (note >= 4'(ftn_pkg::A_OFFSET)) begin
        s7_r  <= note - 4'(ftn_pkg::A_OFFSET);
        s7_qt <= q1;
      end else begin
        s7_r  <= note + 4'(ftn_pkg::SEMIS - ftn_pkg::A_OFFSET);
        s7_qt <= q1 - 7'sd1;
      end
      s7_oct  <= oct;
      s7_emag <= e[34] ? 24'(-e) : 24'(e);
      s7_eneg <= e[34];
      s7_ok   <= s6_ok;
    end
  end

  // stage 8: products
  logic [37:0]       s8_v, s8_cm;
  logic [3:0]        s8_note;
  logic signed [6:0] s8_qt;
  logic signed [4:0] s8_oct;
  logic              s8_eneg, s8_ok;
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s8_v    <= 38'(reference_a4) * 38'(ftn_pkg::RATIO_Q16[s7_r]);
      s8_cm   <= 38'(s7_emag) * 38'(ftn_pkg::CENTS_SCALE);
      s8_note <= s7_note;
      s8_qt   <= s7_qt;
      s8_oct  <= s7_oct;
      s8_eneg <= s7_eneg;
      s8_ok   <= s7_ok;
    end
  end

  // stage 9: octave shift, saturation, cents rounding
  logic signed [7:0] sh;
  logic [5:0]        sh_r;
  logic [3:0]        sh_l;
  logic [38:0]       tsum;
  logic [45:0]       wide;
  logic [23:0]       tgt;
  logic [37:0]       csum;
  logic [12:0]       cmag;
  always_comb begin
    sh   = 8'sd16 - 8'(s8_qt);
    sh_r = sh[5:0];
    sh_l = 4'(-sh);
    tsum = '0;
    if (sh > 8'sd0) begin
      tsum = 39'(s8_v) + (39'd1 << (sh_r - 6'd1));
      wide = 46'(tsum >> sh_r);
    end else begin
      wide = 46'(s8_v) << sh_l;
    end
    tgt  = (|wide[45:24]) ? 24'hFFFFFF : wide[23:0];
    csum = s8_cm + (38'd1 << (ftn_pkg::LOG_Q - 1));
    cmag = csum[ftn_pkg::LOG_Q +: 13];
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      valid_res     <= s8_ok;
      pitch_class   <= s8_ok ? s8_note : '0;
      octave_number <= s8_ok ? s8_oct : '0;
      target_freq   <= s8_ok ? tgt : '0;
      if (!s8_ok) begin
        cent_dev <= '0;
      end else if (s8_eneg) begin
        cent_dev <= -$signed({1'b0, cmag});
      end else begin
        cent_dev <= $signed({1'b0, cmag});
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ftn_checker.sv
// Port-level checks on the note finder's result channel.
// Bound to frequency_to_note_and_cents_unit; no package use.
`timescale 1ns / 1ps
`default_nettype none

module ftn_checker (
  input wire               clk,
  input wire               rst,
  input wire               res_valid,
  input wire               res_stall,
  input wire               valid_res,
  input wire [3:0]         pitch_class,
  input wire signed [4:0]  octave_number,
  input wire [23:0]        target_freq,
  input wire signed [13:0] cent_dev
);

  // nothing leaves the pipe the cycle after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result item straight after reset");

  // an invalid item (zero frequency or zero reference) carries zeros only
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !valid_res |->
      pitch_class == 4'd0 && octave_number == 5'sd0 &&
      target_freq == 24'd0 && cent_dev == 14'sd0)
    else $error("invalid result with nonzero fields");

  a_note_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && valid_res |-> pitch_class < 4'd12)
    else $error("note index out of range");

  a_cents_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> cent_dev >= -14'sd5000 && cent_dev <= 14'sd5000)
    else $error("cents outside half a semitone");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=>
      res_valid && $stable(valid_res) && $stable(pitch_class) &&
      $stable(octave_number) && $stable(target_freq) && $stable(cent_dev))
    else $error("stalled result item changed");

endmodule

bind frequency_to_note_and_cents_unit ftn_checker u_ftn_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .valid_res    (valid_res),
  .pitch_class  (pitch_class),
  .octave_number(octave_number),
  .target_freq  (target_freq),
  .cent_dev     (cent_dev)
);

`default_nettype wire
